// File: rtl/core/bba_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bba_pkg
// shared types and constants of the buddy block allocator
// ---------------------------------------------------------------------------
package bba_pkg;

    localparam int MEM_UNITS = 1024;
    // log2 of the largest power of two not above MEM_UNITS
    localparam int TREE_LG   = $clog2(MEM_UNITS + 1) - 1;
    localparam int NODE_W    = TREE_LG + 1;
    localparam int DEP_W     = $clog2(TREE_LG + 1);
    localparam int NODES     = 2 ** NODE_W;

    typedef enum logic [1:0] {
        NODE_FREE  = 2'd0,
        NODE_SPLIT = 2'd1,
        NODE_ALLOC = 2'd2
    } t_node;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_SPACE = 2'd1,
        STAT_BAD_SIZE = 2'd2,
        STAT_UNALLOC  = 2'd3
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type   req_type;
        logic [11:0] req_size;
        logic [9:0]  free_start;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [9:0]  block_start;
        logic [10:0] blk_size;
    } t_res;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_S_RD,
        ST_S_NODE,
        ST_P_L,
        ST_P_R,
        ST_C_L,
        ST_C_R,
        ST_FAIL,
        ST_FAIL_SIB,
        ST_CARVE,
        ST_F_RD,
        ST_F_NODE,
        ST_U_CHK,
        ST_U_SIB,
        ST_DONE
    } t_state;

endpackage

// File: rtl/core/bba_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bba_ram
// simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/buddy_block_allocator_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// buddy_block_allocator_top
// binary buddy allocator, node states of the tree kept in one ram
// ---------------------------------------------------------------------------
// usage
//   a request word is taken on i_req when start is high and busy is low.
//   req_type selects allocate (size rounded up to a power of two) or free
//   (block start given in free_start). exactly one result word per request
//   appears on o_res for one cycle with o_valid high; the receiver cannot
//   stall it and must take it in that cycle.
// pacing
//   every tree access is one registered ram read, so the walk is paced by
//   the single read port. a free reads one node per level on the way down
//   and checks the buddy of each parent merged; an allocate reads each node
//   the search visits, climbs back level by level after a failed subtree
//   and writes one node per level carved; a bad size goes straight to the
//   result. one request at a time.
// reset
//   i_rst_n is synchronous, active low. after reset a clearing pass writes
//   every tree node free, one node a cycle (2048 nodes at 1024 units);
//   busy stays high until it ends.
// ---------------------------------------------------------------------------
module buddy_block_allocator_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bba_pkg::t_req i_req,
    output logic          o_valid,
    output bba_pkg::t_res o_res
);

    import bba_pkg::*;

    localparam logic [12:0] TOP_SIZE = 13'(1) << TREE_LG;

    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_n, n_n;          // current node index
    logic [DEP_W-1:0]    r_dep, n_dep;      // depth of current node
    logic [DEP_W-1:0]    r_dtgt, n_dtgt;    // depth of the wanted block
    logic [NODE_W-1:0]   r_cnt, n_cnt;      // clearing pass address
    logic [9:0]          r_fstart, n_fstart;
    t_status             r_status, n_status;
    logic [9:0]          r_start, n_start;
    logic [10:0]         r_size, n_size;

    // ram ports
    logic                we;
    logic [NODE_W-1:0]   waddr;
    t_node               wdata;
    logic [NODE_W-1:0]   raddr;
    logic [1:0]          rdata;

    logic [NODE_W-1:0]   left_n, right_n, sib_n, par_n;
    logic [DEP_W-1:0]    lgw;
    logic [DEP_W-1:0]    fbit;

    // block start of node n at depth d
    function automatic logic [9:0] node_start(logic [NODE_W-1:0] n, logic [DEP_W-1:0] d);
        logic [NODE_W+TREE_LG-1:0] t;
        t = {{TREE_LG{1'b0}}, n} << (DEP_W'(TREE_LG) - d);
        return 10'(t[TREE_LG-1:0]);
    endfunction

    function automatic logic [10:0] node_size(logic [DEP_W-1:0] d);
        return 11'(11'(1) << (DEP_W'(TREE_LG) - d));
    endfunction

    bba_ram #(
        .WIDTH (2),
        .DEPTH (NODES)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign left_n  = {r_n[NODE_W-2:0], 1'b0};
    assign right_n = {r_n[NODE_W-2:0], 1'b1};
    assign sib_n   = {r_n[NODE_W-1:1], ~r_n[0]};
    assign par_n   = {1'b0, r_n[NODE_W-1:1]};
    assign fbit    = DEP_W'(TREE_LG - 1) - r_dep;

    // ceiling log2 of the request size, narrow compare chain
    always_comb begin
        lgw = '0;
        for (int i = 0; i < TREE_LG; i++) begin
            if (i_req.req_size > 12'(1 << i)) begin
                lgw = DEP_W'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_n      <= n_n;
        r_dep    <= n_dep;
        r_dtgt   <= n_dtgt;
        r_fstart <= n_fstart;
        r_status <= n_status;
        r_start  <= n_start;
        r_size   <= n_size;
    end

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_dep    = r_dep;
        n_dtgt   = r_dtgt;
        n_cnt    = r_cnt;
        n_fstart = r_fstart;
        n_status = r_status;
        n_start  = r_start;
        n_size   = r_size;
        we       = 1'b0;
        waddr    = r_n;
        wdata    = NODE_FREE;
        raddr    = r_n;

        case (r_state)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = r_cnt;
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_n      = NODE_W'(1);
                    n_dep    = '0;
                    n_fstart = i_req.free_start;
                    n_status = STAT_OK;
                    n_start  = '0;
                    n_size   = '0;
                    n_dtgt   = DEP_W'(TREE_LG) - lgw;
                    if (i_req.req_type == REQ_FREE) begin
                        n_state = ST_F_RD;
                    end else if (i_req.req_size == '0 ||
                                 {1'b0, i_req.req_size} > TOP_SIZE) begin
                        n_status = STAT_BAD_SIZE;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_S_RD;
                    end
                end
            end
            // search: fetch node state
            ST_S_RD: begin
                n_state = ST_S_NODE;
            end
            ST_S_NODE: begin
                raddr = left_n;
                if (rdata == NODE_FREE && r_n == NODE_W'(1)) begin
                    n_state = ST_CARVE;
                end else if (rdata != NODE_SPLIT || r_dep >= DEP_W'(TREE_LG) ||
                             r_dep + 1'b1 > r_dtgt) begin
                    n_state = ST_FAIL;
                end else if (r_dep + 1'b1 == r_dtgt) begin
                    n_state = ST_P_L;
                end else begin
                    n_state = ST_C_L;
                end
            end
            // node of twice the wanted size: take a free half
            ST_P_L: begin
                raddr = right_n;
                if (rdata == NODE_FREE) begin
                    we      = 1'b1;
                    waddr   = left_n;
                    wdata   = NODE_ALLOC;
                    n_start = node_start(left_n, r_dep + 1'b1);
                    n_size  = node_size(r_dtgt);
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_P_R;
                end
            end
            ST_P_R: begin
                if (rdata == NODE_FREE) begin
                    we      = 1'b1;
                    waddr   = right_n;
                    wdata   = NODE_ALLOC;
                    n_start = node_start(right_n, r_dep + 1'b1);
                    n_size  = node_size(r_dtgt);
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_FAIL;
                end
            end
            // larger node: descend into a used child first
            ST_C_L: begin
                raddr = right_n;
                if (rdata != NODE_FREE) begin
                    n_n     = left_n;
                    n_dep   = r_dep + 1'b1;
                    n_state = ST_S_RD;
                end else begin
                    n_state = ST_C_R;
                end
            end
            ST_C_R: begin
                n_dep = r_dep + 1'b1;
                if (rdata != NODE_FREE) begin
                    n_n     = right_n;
                    n_state = ST_S_RD;
                end else begin
                    n_n     = left_n;
                    n_state = ST_CARVE;
                end
            end
            // search of r_n failed: try its buddy, else fail its parent in turn
            ST_FAIL: begin
                raddr = sib_n;
                if (r_n == NODE_W'(1)) begin
                    n_status = STAT_NO_SPACE;
                    n_state  = ST_DONE;
                end else begin
                    n_state = ST_FAIL_SIB;
                end
            end
            ST_FAIL_SIB: begin
                if (!r_n[0]) begin
                    n_n     = sib_n;
                    n_state = (rdata != NODE_FREE) ? ST_S_RD : ST_CARVE;
                end else if (rdata == NODE_FREE) begin
                    n_n     = sib_n;
                    n_state = ST_CARVE;
                end else begin
                    n_n     = par_n;
                    n_dep   = r_dep - 1'b1;
                    n_state = ST_FAIL;
                end
            end
            // split down the left edge to the wanted size
            ST_CARVE: begin
                we = 1'b1;
                if (r_dep < r_dtgt) begin
                    wdata = NODE_SPLIT;
                    n_n   = left_n;
                    n_dep = r_dep + 1'b1;
                end else begin
                    wdata   = NODE_ALLOC;
                    n_start = node_start(r_n, r_dep);
                    n_size  = node_size(r_dtgt);
                    n_state = ST_DONE;
                end
            end
            // free: walk down along free_start
            ST_F_RD: begin
                n_state = ST_F_NODE;
            end
            ST_F_NODE: begin
                if (rdata == NODE_ALLOC) begin
                    if (node_start(r_n, r_dep) == r_fstart) begin
                        we      = 1'b1;
                        wdata   = NODE_FREE;
                        n_start = r_fstart;
                        n_size  = node_size(r_dep);
                        n_state = ST_U_CHK;
                    end else begin
                        n_status = STAT_UNALLOC;
                        n_state  = ST_DONE;
                    end
                end else if (rdata != NODE_SPLIT || r_dep >= DEP_W'(TREE_LG)) begin
                    n_status = STAT_UNALLOC;
                    n_state  = ST_DONE;
                end else begin
                    n_n     = r_fstart[fbit] ? right_n : left_n;
                    n_dep   = r_dep + 1'b1;
                    n_state = ST_F_RD;
                end
            end
            // merge upward while the buddy is free
            ST_U_CHK: begin
                raddr   = sib_n;
                n_state = (r_n == NODE_W'(1)) ? ST_DONE : ST_U_SIB;
            end
            ST_U_SIB: begin
                if (rdata == NODE_FREE) begin
                    we      = 1'b1;
                    waddr   = par_n;
                    wdata   = NODE_FREE;
                    n_n     = par_n;
                    n_dep   = r_dep - 1'b1;
                    n_state = ST_U_CHK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy              = (r_state != ST_IDLE);
    assign o_valid           = (r_state == ST_DONE);
    assign o_res.status      = r_status;
    assign o_res.block_start = r_start;
    assign o_res.blk_size    = r_size;

`ifndef SYNTHESIS
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request not taken");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status != STAT_OK) |->
        (o_res.blk_size == '0 && o_res.block_start == '0))
        else $error("error result carries a block");

    a_ok_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == STAT_OK) |-> $onehot(o_res.blk_size))
        else $error("block size not a power of two");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result repeated");
`endif

endmodule

// File: test/tb_buddy_block_allocator_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_buddy_block_allocator_top
// self-checking bench for the buddy block allocator: a behavioral model of
// the node tree predicts every result word, directed cases first, then
// random alloc/free traffic that fills and drains the memory
// ---------------------------------------------------------------------------
module tb_buddy_block_allocator_top;

    import bba_pkg::*;

    localparam int TOP   = 1024;   // tree size in units
    localparam int LIMIT = 40000000;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_valid;
    t_res  o_res;

    buddy_block_allocator_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_res  (o_res)
    );

    // model state: node tree, root at index 1
    t_node tree_nodes [2*TOP];
    t_res  pending_res [$];
    // starts of blocks the model holds as allocated, used to aim frees
    int    live_starts [$];
    int    errors = 0;
    int    cycles = 0;
    int    n_alloc_ok, n_free_ok, n_nospace, n_badsize, n_unalloc;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int exp_v);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp_v, cycles);
        errors++;
    endtask

    // result checker: every strobed word must match the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_res want;
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = pending_res.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch("status", o_res.status, want.status);
                if (o_res.block_start !== want.block_start)
                    report_mismatch("block_start", o_res.block_start, want.block_start);
                if (o_res.blk_size !== want.blk_size)
                    report_mismatch("blk_size", o_res.blk_size, want.blk_size);
            end
        end
    end

    // split down the left edge until the block matches the wanted size
    function automatic int carve_down(int n, int sz, int st, int want, ref int at);
        while (sz > want) begin
            tree_nodes[n] = NODE_SPLIT;
            n = 2 * n;
            sz = sz / 2;
        end
        tree_nodes[n] = NODE_ALLOC;
        at = st;
        return n;
    endfunction

    function automatic int find_fit(int n, int sz, int st, int want, ref int at);
        int half, l, r, got;
        bit lu, ru;
        if (tree_nodes[n] != NODE_SPLIT || sz < 2) return 0;
        half = sz / 2;
        l = 2 * n;
        r = l + 1;
        if (sz == 2 * want) begin
            if (tree_nodes[l] == NODE_FREE) begin
                tree_nodes[l] = NODE_ALLOC;
                at = st;
                return l;
            end
            if (tree_nodes[r] == NODE_FREE) begin
                tree_nodes[r] = NODE_ALLOC;
                at = st + half;
                return r;
            end
            return 0;
        end
        if (sz < 2 * want) return 0;
        lu = tree_nodes[l] != NODE_FREE;
        ru = tree_nodes[r] != NODE_FREE;
        if (lu && ru) begin
            got = find_fit(l, half, st, want, at);
            if (got == 0) got = find_fit(r, half, st + half, want, at);
            return got;
        end
        if (lu) begin
            got = find_fit(l, half, st, want, at);
            if (got == 0) got = carve_down(r, half, st + half, want, at);
            return got;
        end
        got = find_fit(r, half, st + half, want, at);
        if (got == 0) got = carve_down(l, half, st, want, at);
        return got;
    endfunction

    // predicted result word of one request, tree updated in place
    function automatic t_res predict_result(t_req rq);
        t_res res;
        int want, at, got, n, sz, st, fs;
        bit found;
        res = '0;
        res.status = STAT_OK;
        if (rq.req_type == REQ_ALLOC) begin
            if (rq.req_size == 0 || rq.req_size > TOP) begin
                res.status = STAT_BAD_SIZE;
            end else begin
                want = 1;
                at = 0;
                while (want < rq.req_size) want = want << 1;
                if (tree_nodes[1] == NODE_FREE) got = carve_down(1, TOP, 0, want, at);
                else got = find_fit(1, TOP, 0, want, at);
                if (got == 0) begin
                    res.status = STAT_NO_SPACE;
                end else begin
                    res.block_start = at[9:0];
                    res.blk_size = want[10:0];
                    live_starts.push_back(at);
                end
            end
        end else begin
            n = 1;
            sz = TOP;
            st = 0;
            found = 0;
            fs = rq.free_start;
            forever begin
                if (tree_nodes[n] == NODE_ALLOC) begin
                    found = (st == fs);
                    break;
                end
                if (tree_nodes[n] != NODE_SPLIT || sz < 2) break;
                sz = sz / 2;
                if (fs < st + sz) begin
                    n = 2 * n;
                end else begin
                    n = 2 * n + 1;
                    st += sz;
                end
            end
            if (!found) begin
                res.status = STAT_UNALLOC;
            end else begin
                res.block_start = st[9:0];
                res.blk_size = sz[10:0];
                tree_nodes[n] = NODE_FREE;
                // merge parents whose halves are both free
                while (n > 1 && tree_nodes[n ^ 1] == NODE_FREE) begin
                    n = n >> 1;
                    tree_nodes[n] = NODE_FREE;
                end
                foreach (live_starts[k])
                    if (live_starts[k] == st) begin
                        live_starts.delete(k);
                        break;
                    end
            end
        end
        case (res.status)
            STAT_OK: if (rq.req_type == REQ_ALLOC) n_alloc_ok++; else n_free_ok++;
            STAT_NO_SPACE: n_nospace++;
            STAT_BAD_SIZE: n_badsize++;
            default: n_unalloc++;
        endcase
        return res;
    endfunction

    // random gap, mostly short, sometimes long, often none; the task always
    // waits on a falling edge, so start drops between words
    task automatic idle_gap();
        int g;
        g = $urandom_range(0, 9);
        if (g < 5) g = 0;
        else if (g < 9) g = $urandom_range(1, 3);
        else g = $urandom_range(10, 60);
        repeat (g + 1) @(negedge i_clk);
    endtask

    // send one request word and queue its prediction on acceptance
    task automatic send_request(t_req rq);
        idle_gap();
        start <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_res.push_back(predict_result(rq));
        @(negedge i_clk);
        start <= 1'b0;
        i_req <= t_req'($bits(t_req)'($urandom));
    endtask

    task automatic do_alloc(int size);
        t_req rq;
        rq.req_type = REQ_ALLOC;
        rq.req_size = size[11:0];
        rq.free_start = 10'($urandom);
        send_request(rq);
    endtask

    task automatic do_free(int at);
        t_req rq;
        rq.req_type = REQ_FREE;
        rq.req_size = 12'($urandom);
        rq.free_start = at[9:0];
        send_request(rq);
    endtask

    task automatic drain();
        while (pending_res.size() != 0) @(negedge i_clk);
    endtask

    // extremes of size, no space, bad sizes, frees inside and outside blocks
    task automatic test_directed();
        do_alloc(0);
        do_alloc(4095);
        do_alloc(1025);
        do_alloc(1024);          // whole memory
        do_alloc(1);             // no space
        do_free(512);            // inside a block
        do_free(0);
        do_free(0);              // double free
        do_alloc(1);
        do_alloc(3);
        do_alloc(2);
        do_alloc(513);
        do_alloc(300);
        do_free(1023);           // inside a block
        do_free(4);
        do_free(0);
        do_free(2);
        do_free(512);
        do_alloc(2048);
        do_alloc(1);
        do_free(0);
        drain();
    endtask

    // mostly well formed traffic: allocs of small sizes, frees of live blocks
    task automatic test_random(int count);
        int r, sz, idx;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                case ($urandom_range(0, 9))
                    0: sz = $urandom_range(0, 4095);
                    1: sz = $urandom_range(65, 1024);
                    default: sz = $urandom_range(1, 64);
                endcase
                do_alloc(sz);
            end else if (r < 88 && live_starts.size() != 0) begin
                idx = $urandom_range(0, live_starts.size() - 1);
                do_free(live_starts[idx]);
            end else begin
                do_free($urandom_range(0, 1023));
            end
        end
        drain();
        // release everything so later traffic starts empty too
        while (live_starts.size() != 0) do_free(live_starts[0]);
        drain();
    endtask

    initial begin
        n_alloc_ok = 0; n_free_ok = 0; n_nospace = 0; n_badsize = 0; n_unalloc = 0;
        foreach (tree_nodes[k]) tree_nodes[k] = NODE_FREE;
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(600);
        test_random(650);

        repeat (100) @(negedge i_clk);
        $display("allocs ok %0d, frees ok %0d, no space %0d, bad size %0d, bad free %0d",
                 n_alloc_ok, n_free_ok, n_nospace, n_badsize, n_unalloc);
        if (errors == 0 && pending_res.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
